// ===== src/sqd_pkg.sv =====
// sqd_pkg: shared types and constants of the shortest-queue dispatcher.
// No dependencies; used by sqd_front, sqd_back and shortest_queue_dispatcher.
`timescale 1ns / 1ps

package sqd_pkg;

   // fixed field widths of the request and response words
   localparam int WIDX_W    = 3;
   localparam int HANDLER_W = 8;
   localparam int STATUS_W  = 2;
   localparam int OP_W      = 2;

   // configuration register
   localparam int          CFG_W       = 4;
   localparam logic [3:0]  CFG_RESET   = 4'd8;
   localparam int          CSR_ADDR_W  = 3;
   localparam int          CSR_DATA_W  = 32;
   localparam logic [0:0]  REG_WORKERS_IN_USE = 1'b0;

   // slots in each of the small word queues
   localparam int          QUEUE_SLOTS = 2;

   // request function codes
   localparam logic FUNC_SCHEDULE = 1'b0;
   localparam logic FUNC_TAKE     = 1'b1;

   // classified operations handed from front to back
   localparam logic [OP_W-1:0] OP_SCHED    = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE     = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE_BAD = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // control part of a command word
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [WIDX_W-1:0] widx;
   } cmd_ctrl_type;

endpackage

// ===== src/shortest_queue_dispatcher.sv =====
// A request word passes the front command queue, the back end's execute and respond steps
// around the single-write, single-read queue memory, then the response queue; the back end
// takes no new word until it has responded to the last one. Two words queue on each side.
// Reset (synchronous): fill counts and ring pointers clear, workers_in_use returns to 8,
// both word queues empty; queue memory contents are left as they are.
// Top level: CSR register, sqd_front and sqd_back. Depends on sqd_pkg.
`timescale 1ns / 1ps

module shortest_queue_dispatcher #(
   parameter int WORKERS        = 8,
   parameter int QUEUE_DEPTH    = 32,
   parameter int ARGUMENT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request queue
   input  logic                               push,
   output logic                               full,
   input  logic                               req_func,
   input  logic [sqd_pkg::WIDX_W-1:0]         req_worker_index,
   input  logic [sqd_pkg::HANDLER_W-1:0]      req_handler_id,
   input  logic [ARGUMENT_WIDTH-1:0]          req_work_argument,
   // response queue
   output logic                               empty,
   input  logic                               pop,
   output logic [sqd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sqd_pkg::WIDX_W-1:0]         rsp_chosen_worker,
   output logic                               rsp_wake_worker,
   output logic [sqd_pkg::HANDLER_W-1:0]      rsp_taken_handler_id,
   output logic [ARGUMENT_WIDTH-1:0]          rsp_taken_argument,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sqd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sqd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sqd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   logic [sqd_pkg::CFG_W-1:0]     workers_ff, workers_in;
   logic                          csr_hit;
   logic                          cmd_valid;
   logic                          cmd_pop;
   sqd_pkg::cmd_ctrl_type         cmd_ctrl;
   logic [sqd_pkg::HANDLER_W-1:0] cmd_handler;
   logic [ARGUMENT_WIDTH-1:0]     cmd_arg;

   // configuration register, decoded on the word address bit
   assign pready  = 1'b1;
   assign csr_hit = (paddr[sqd_pkg::CSR_ADDR_W-1] == sqd_pkg::REG_WORKERS_IN_USE);
   assign workers_in = (psel && penable && pwrite && pready && csr_hit)
                       ? pwdata[sqd_pkg::CFG_W-1:0] : workers_ff;
   assign prdata = csr_hit ? {{(sqd_pkg::CSR_DATA_W - sqd_pkg::CFG_W){1'b0}}, workers_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) workers_ff <= sqd_pkg::CFG_RESET;
      else workers_ff <= workers_in;
   end

   sqd_front #(
      .WORKERS        (WORKERS),
      .ARGUMENT_WIDTH (ARGUMENT_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_worker_index  (req_worker_index),
      .req_handler_id    (req_handler_id),
      .req_work_argument (req_work_argument),
      .cmd_valid         (cmd_valid),
      .cmd_ctrl          (cmd_ctrl),
      .cmd_handler       (cmd_handler),
      .cmd_arg           (cmd_arg),
      .cmd_pop           (cmd_pop)
   );

   sqd_back #(
      .WORKERS        (WORKERS),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .ARGUMENT_WIDTH (ARGUMENT_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .workers_in_use       (workers_ff),
      .cmd_valid            (cmd_valid),
      .cmd_ctrl             (cmd_ctrl),
      .cmd_handler          (cmd_handler),
      .cmd_arg              (cmd_arg),
      .cmd_pop              (cmd_pop),
      .rsp_empty            (empty),
      .rsp_pop              (pop),
      .rsp_status           (rsp_status),
      .rsp_chosen_worker    (rsp_chosen_worker),
      .rsp_wake_worker      (rsp_wake_worker),
      .rsp_taken_handler_id (rsp_taken_handler_id),
      .rsp_taken_argument   (rsp_taken_argument)
   );

endmodule

// ===== src/sqd_front.sv =====
// sqd_front: accepts request words, classifies them and holds them in a
// two-slot command queue for the back end. Depends on sqd_pkg.
`timescale 1ns / 1ps

module sqd_front #(
   parameter int WORKERS        = 8,
   parameter int ARGUMENT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_func,
   input  logic [sqd_pkg::WIDX_W-1:0]         req_worker_index,
   input  logic [sqd_pkg::HANDLER_W-1:0]      req_handler_id,
   input  logic [ARGUMENT_WIDTH-1:0]          req_work_argument,
   output logic                               cmd_valid,
   output sqd_pkg::cmd_ctrl_type              cmd_ctrl,
   output logic [sqd_pkg::HANDLER_W-1:0]      cmd_handler,
   output logic [ARGUMENT_WIDTH-1:0]          cmd_arg,
   input  logic                               cmd_pop
);

   sqd_pkg::cmd_ctrl_type                ctrl_ff [sqd_pkg::QUEUE_SLOTS];
   logic [sqd_pkg::HANDLER_W-1:0]        hdl_ff  [sqd_pkg::QUEUE_SLOTS];
   logic [ARGUMENT_WIDTH-1:0]            arg_ff  [sqd_pkg::QUEUE_SLOTS];
   sqd_pkg::cmd_ctrl_type                ctrl_in;
   logic                                 wr_ptr_ff, wr_ptr_in;
   logic                                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]                           cnt_ff, cnt_in;
   logic                                 accept;

   // classify: a take naming a worker that does not exist is answered empty
   always_comb begin
      ctrl_in.widx = req_worker_index;
      unique case (req_func)
         sqd_pkg::FUNC_SCHEDULE: ctrl_in.op = sqd_pkg::OP_SCHED;
         sqd_pkg::FUNC_TAKE: begin
            if (32'(req_worker_index) >= WORKERS) ctrl_in.op = sqd_pkg::OP_TAKE_BAD;
            else ctrl_in.op = sqd_pkg::OP_TAKE;
         end
         default: ctrl_in.op = sqd_pkg::OP_SCHED;
      endcase
   end

   // queue pointers and fill
   assign full      = (cnt_ff == 2'(sqd_pkg::QUEUE_SLOTS));
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign wr_ptr_in = wr_ptr_ff ^ accept;
   assign rd_ptr_in = rd_ptr_ff ^ cmd_pop;
   assign cnt_in    = cnt_ff + 2'(accept) - 2'(cmd_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // command slots
   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff[wr_ptr_ff] <= ctrl_in;
         hdl_ff[wr_ptr_ff]  <= req_handler_id;
         arg_ff[wr_ptr_ff]  <= req_work_argument;
      end
   end

   assign cmd_ctrl    = ctrl_ff[rd_ptr_ff];
   assign cmd_handler = hdl_ff[rd_ptr_ff];
   assign cmd_arg     = arg_ff[rd_ptr_ff];

endmodule

// ===== src/sqd_back.sv =====
// sqd_back: executes commands against the per-worker ring queues (shortest
// queue pick, queue memory, pointers, fill counts) and queues the responses.
// Depends on sqd_pkg.
`timescale 1ns / 1ps

module sqd_back #(
   parameter int WORKERS        = 8,
   parameter int QUEUE_DEPTH    = 32,
   parameter int ARGUMENT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sqd_pkg::CFG_W-1:0]          workers_in_use,
   input  logic                               cmd_valid,
   input  sqd_pkg::cmd_ctrl_type              cmd_ctrl,
   input  logic [sqd_pkg::HANDLER_W-1:0]      cmd_handler,
   input  logic [ARGUMENT_WIDTH-1:0]          cmd_arg,
   output logic                               cmd_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sqd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sqd_pkg::WIDX_W-1:0]         rsp_chosen_worker,
   output logic                               rsp_wake_worker,
   output logic [sqd_pkg::HANDLER_W-1:0]      rsp_taken_handler_id,
   output logic [ARGUMENT_WIDTH-1:0]          rsp_taken_argument
);

   localparam int IDX_W     = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W    = IDX_W + PTR_W;
   localparam int MEM_DEPTH = WORKERS * (2 ** PTR_W);
   localparam int ENTRY_W   = sqd_pkg::HANDLER_W + ARGUMENT_WIDTH;

   localparam logic ST_EXEC = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic                         st_ff, st_in;
   logic [CNT_W-1:0]             cnt_ff  [WORKERS];
   logic [CNT_W-1:0]             cnt_in  [WORKERS];
   logic [PTR_W-1:0]             head_ff [WORKERS];
   logic [PTR_W-1:0]             head_in [WORKERS];
   logic [PTR_W-1:0]             tail_ff [WORKERS];
   logic [PTR_W-1:0]             tail_in [WORKERS];
   logic [ENTRY_W-1:0]           mem     [MEM_DEPTH];
   logic [ENTRY_W-1:0]           rd_data_ff;

   logic [sqd_pkg::CFG_W-1:0]    n_eff;
   logic [WORKERS-1:0]           win;
   logic [IDX_W-1:0]             best;
   logic [IDX_W-1:0]             take_idx;
   logic                         exec_go;
   logic                         sched_full;
   logic                         take_empty;
   logic                         do_write;
   logic                         do_read;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;

   // response fields held from execute to respond
   logic [sqd_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [sqd_pkg::WIDX_W-1:0]   chosen_ff, chosen_in;
   logic                         wake_ff, wake_in;
   logic                         take_ok_ff, take_ok_in;

   // response queue
   logic [sqd_pkg::STATUS_W-1:0]  rq_status_ff [sqd_pkg::QUEUE_SLOTS];
   logic [sqd_pkg::WIDX_W-1:0]    rq_chosen_ff [sqd_pkg::QUEUE_SLOTS];
   logic                          rq_wake_ff   [sqd_pkg::QUEUE_SLOTS];
   logic [sqd_pkg::HANDLER_W-1:0] rq_hdl_ff    [sqd_pkg::QUEUE_SLOTS];
   logic [ARGUMENT_WIDTH-1:0]     rq_arg_ff    [sqd_pkg::QUEUE_SLOTS];
   logic                          rq_wr_ff, rq_wr_in;
   logic                          rq_rd_ff, rq_rd_in;
   logic [1:0]                    rq_cnt_ff, rq_cnt_in;
   logic                          rq_push;
   logic                          rq_pop;

   // effective worker count: zero counts as one, saturated at WORKERS
   always_comb begin
      if (workers_in_use == '0) n_eff = sqd_pkg::CFG_W'(1);
      else if (32'(workers_in_use) > WORKERS) n_eff = sqd_pkg::CFG_W'(WORKERS);
      else n_eff = workers_in_use;
   end

   // shortest queue: worker i wins when it beats every lower index strictly
   // and every higher index by at most a tie
   always_comb begin
      best = '0;
      for (int i = 0; i < WORKERS; i++) begin
         win[i] = (i < 32'(n_eff));
         for (int j = 0; j < WORKERS; j++) begin
            if (j < 32'(n_eff) && j < i && !(cnt_ff[i] < cnt_ff[j])) win[i] = 1'b0;
            if (j < 32'(n_eff) && j > i && !(cnt_ff[i] <= cnt_ff[j])) win[i] = 1'b0;
         end
         if (win[i]) best = best | IDX_W'(i);
      end
   end

   // execute decisions
   assign exec_go    = (st_ff == ST_EXEC) && cmd_valid;
   assign take_idx   = IDX_W'(cmd_ctrl.widx);
   assign sched_full = (cnt_ff[best] == CNT_W'(QUEUE_DEPTH));
   assign take_empty = (cmd_ctrl.op == sqd_pkg::OP_TAKE_BAD) || (cnt_ff[take_idx] == '0);
   assign do_write   = exec_go && (cmd_ctrl.op == sqd_pkg::OP_SCHED) && !sched_full;
   assign do_read    = exec_go && (cmd_ctrl.op != sqd_pkg::OP_SCHED) && !take_empty;
   assign wr_addr    = {best, tail_ff[best]};
   assign rd_addr    = {take_idx, head_ff[take_idx]};

   // pointer and fill updates
   always_comb begin
      for (int i = 0; i < WORKERS; i++) begin
         cnt_in[i]  = cnt_ff[i];
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
      end
      if (do_write) begin
         cnt_in[best]  = cnt_ff[best] + CNT_W'(1);
         tail_in[best] = (tail_ff[best] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : tail_ff[best] + PTR_W'(1);
      end
      if (do_read) begin
         cnt_in[take_idx]  = cnt_ff[take_idx] - CNT_W'(1);
         head_in[take_idx] = (head_ff[take_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : head_ff[take_idx] + PTR_W'(1);
      end
   end

   // response fields decided at execute
   always_comb begin
      status_in  = status_ff;
      chosen_in  = chosen_ff;
      wake_in    = wake_ff;
      take_ok_in = take_ok_ff;
      if (exec_go) begin
         if (cmd_ctrl.op == sqd_pkg::OP_SCHED) begin
            status_in  = sched_full ? sqd_pkg::STATUS_FULL : sqd_pkg::STATUS_DONE;
            chosen_in  = sqd_pkg::WIDX_W'(best);
            wake_in    = !sched_full && (cnt_ff[best] == '0);
            take_ok_in = 1'b0;
         end else begin
            status_in  = take_empty ? sqd_pkg::STATUS_EMPTY : sqd_pkg::STATUS_DONE;
            chosen_in  = cmd_ctrl.widx;
            wake_in    = 1'b0;
            take_ok_in = !take_empty;
         end
      end
   end

   // sequencer: execute, then respond once the response queue has room
   assign rq_push = (st_ff == ST_RESP) && (rq_cnt_ff != 2'(sqd_pkg::QUEUE_SLOTS));
   assign cmd_pop = rq_push;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_EXEC: if (cmd_valid) st_in = ST_RESP;
         ST_RESP: if (rq_push) st_in = ST_EXEC;
         default: st_in = ST_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_EXEC;
         for (int i = 0; i < WORKERS; i++) begin
            cnt_ff[i]  <= '0;
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         for (int i = 0; i < WORKERS; i++) begin
            cnt_ff[i]  <= cnt_in[i];
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      chosen_ff  <= chosen_in;
      wake_ff    <= wake_in;
      take_ok_ff <= take_ok_in;
   end

   // queue memory: at most one write or one registered read per cycle, in the execute step only
   always_ff @(posedge clock) begin
      if (do_write) mem[wr_addr] <= {cmd_handler, cmd_arg};
   end

   always_ff @(posedge clock) begin
      if (do_read) rd_data_ff <= mem[rd_addr];
   end

   // response queue
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign rq_wr_in  = rq_wr_ff ^ rq_push;
   assign rq_rd_in  = rq_rd_ff ^ rq_pop;
   assign rq_cnt_in = rq_cnt_ff + 2'(rq_push) - 2'(rq_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   // taken fields are zero unless a pop succeeded
   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_status_ff[rq_wr_ff] <= status_ff;
         rq_chosen_ff[rq_wr_ff] <= chosen_ff;
         rq_wake_ff[rq_wr_ff]   <= wake_ff;
         rq_hdl_ff[rq_wr_ff]    <= take_ok_ff ? rd_data_ff[ENTRY_W-1 -: sqd_pkg::HANDLER_W] : '0;
         rq_arg_ff[rq_wr_ff]    <= take_ok_ff ? rd_data_ff[ARGUMENT_WIDTH-1:0] : '0;
      end
   end

   assign rsp_status           = rq_status_ff[rq_rd_ff];
   assign rsp_chosen_worker    = rq_chosen_ff[rq_rd_ff];
   assign rsp_wake_worker      = rq_wake_ff[rq_rd_ff];
   assign rsp_taken_handler_id = rq_hdl_ff[rq_rd_ff];
   assign rsp_taken_argument   = rq_arg_ff[rq_rd_ff];

`ifndef SYNTHESIS
   // respond is entered only from an execute that had a command
   a_resp_after_exec: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RESP && !$past(reset)) |->
         ($past(st_ff) == ST_RESP || ($past(st_ff) == ST_EXEC && $past(cmd_valid))))
      else $error("respond state entered without an executed command");

   // the executed command stays at the head of the front queue until popped
   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RESP) |-> cmd_valid)
      else $error("command lost while its response is pending");

   // wake only on a successful schedule
   a_wake_done: assert property (@(posedge clock) disable iff (reset)
      (rq_push && wake_ff) |-> (status_ff == sqd_pkg::STATUS_DONE && !take_ok_ff))
      else $error("wake raised on a word that did not schedule");

   // a rejected or empty word never carries popped data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rq_push && status_ff != sqd_pkg::STATUS_DONE) |-> !take_ok_ff)
      else $error("failed word carries popped data");

   // the response queue is empty right after reset
   a_rq_reset: assert property (@(posedge clock)
      $past(reset) |-> (rq_cnt_ff == 2'd0))
      else $error("response queue not empty after reset");
`endif

endmodule

// ===== verif/shortest_queue_dispatcher_tb.sv =====
// shortest_queue_dispatcher_tb: self-checking bench for the shortest-queue dispatcher.
// A directed table, then random schedule/take traffic over several workers_in_use settings,
// each word checked against its typed row or an in-bench queue predictor. Depends on sqd_pkg.
`timescale 1ns / 1ps

module shortest_queue_dispatcher_tb;

   localparam int WORKERS     = 8;
   localparam int QUEUE_DEPTH = 32;
   localparam int ARG_W       = 32;
   localparam int LIMIT       = 200000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [sqd_pkg::STATUS_W-1:0]  status;
      logic [sqd_pkg::WIDX_W-1:0]    worker;
      logic                          wake;
      logic [sqd_pkg::HANDLER_W-1:0] hid;
      logic [ARG_W-1:0]              arg;
   } rsp_word_type;

   typedef struct packed {
      logic                          func;
      logic [sqd_pkg::WIDX_W-1:0]    widx;
      logic [sqd_pkg::HANDLER_W-1:0] hid;
      logic [ARG_W-1:0]              arg;
      logic                          typed;
      rsp_word_type                  want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic push, full, empty, pop;
   logic                          req_func;
   logic [sqd_pkg::WIDX_W-1:0]    req_worker_index;
   logic [sqd_pkg::HANDLER_W-1:0] req_handler_id;
   logic [ARG_W-1:0]              req_work_argument;
   logic [sqd_pkg::STATUS_W-1:0]  rsp_status;
   logic [sqd_pkg::WIDX_W-1:0]    rsp_chosen_worker;
   logic                          rsp_wake_worker;
   logic [sqd_pkg::HANDLER_W-1:0] rsp_taken_handler_id;
   logic [ARG_W-1:0]              rsp_taken_argument;
   logic                           psel, penable, pwrite, pready;
   logic [sqd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [sqd_pkg::CSR_DATA_W-1:0] pwdata, prdata;

   // predictor state: per-worker rings and the register copy
   int                            fill_count [WORKERS] = '{default: 0};
   int                            head_ptr [WORKERS]   = '{default: 0};
   int                            tail_ptr [WORKERS]   = '{default: 0};
   logic [sqd_pkg::HANDLER_W-1:0] slot_handler [WORKERS][QUEUE_DEPTH];
   logic [ARG_W-1:0]              slot_arg [WORKERS][QUEUE_DEPTH];
   logic [sqd_pkg::CFG_W-1:0]     workers_cfg = sqd_pkg::CFG_RESET;

   rsp_word_type expected_words [$];
   int        words_sent = 0;
   int        mismatches = 0;
   int        cycles     = 0;
   bit        calm       = 1'b0;
   bit        held_off   = 1'b0;

   // directed rows; typed expectations only where they follow at a glance
   dir_row_type directed_rows [22] = '{
      '{sqd_pkg::FUNC_TAKE, 3'd0, 8'h00, 32'h0, 1'b1,
        '{sqd_pkg::STATUS_EMPTY, 3'd0, 1'b0, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_TAKE, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{sqd_pkg::STATUS_EMPTY, 3'd7, 1'b0, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd5, 8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{sqd_pkg::STATUS_DONE, 3'd0, 1'b1, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd2, 8'h00, 32'h0, 1'b1,
        '{sqd_pkg::STATUS_DONE, 3'd1, 1'b1, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd7, 8'hA5, 32'h5A5A_5A5A, 1'b1,
        '{sqd_pkg::STATUS_DONE, 3'd2, 1'b1, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_TAKE, 3'd0, 8'h00, 32'h0, 1'b1,
        '{sqd_pkg::STATUS_DONE, 3'd0, 1'b0, 8'hFF, 32'hFFFF_FFFF}},
      '{sqd_pkg::FUNC_TAKE, 3'd0, 8'h00, 32'h0, 1'b1,
        '{sqd_pkg::STATUS_EMPTY, 3'd0, 1'b0, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_TAKE, 3'd1, 8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{sqd_pkg::STATUS_DONE, 3'd1, 1'b0, 8'h00, 32'h0}},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd0, 8'h01, 32'h0000_0001, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd1, 8'h80, 32'h8000_0000, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd2, 8'h7F, 32'h7FFF_FFFF, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd3, 8'h3C, 32'hDEAD_BEEF, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd4, 8'hC3, 32'h1234_5678, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd6, 8'h55, 32'hAAAA_5555, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd7, 8'hAA, 32'h5555_AAAA, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd0, 8'h0F, 32'hF0F0_0F0F, 1'b0, '0},
      '{sqd_pkg::FUNC_TAKE, 3'd2, 8'h00, 32'h0, 1'b0, '0},
      '{sqd_pkg::FUNC_TAKE, 3'd3, 8'h00, 32'h0, 1'b0, '0},
      '{sqd_pkg::FUNC_TAKE, 3'd7, 8'h00, 32'h0, 1'b0, '0},
      '{sqd_pkg::FUNC_TAKE, 3'd7, 8'h00, 32'h0, 1'b0, '0},
      '{sqd_pkg::FUNC_TAKE, 3'd6, 8'h00, 32'h0, 1'b0, '0},
      '{sqd_pkg::FUNC_SCHEDULE, 3'd4, 8'hE7, 32'h0F0F_F0F0, 1'b0, '0}
   };

   shortest_queue_dispatcher #(
      .WORKERS        (WORKERS),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .ARGUMENT_WIDTH (ARG_W)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_func             (req_func),
      .req_worker_index     (req_worker_index),
      .req_handler_id       (req_handler_id),
      .req_work_argument    (req_work_argument),
      .empty                (empty),
      .pop                  (pop),
      .rsp_status           (rsp_status),
      .rsp_chosen_worker    (rsp_chosen_worker),
      .rsp_wake_worker      (rsp_wake_worker),
      .rsp_taken_handler_id (rsp_taken_handler_id),
      .rsp_taken_argument   (rsp_taken_argument),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // shortest-queue choice and ring updates for one accepted word
   function automatic rsp_word_type predict_dispatch(
      input logic func,
      input logic [sqd_pkg::WIDX_W-1:0] widx,
      input logic [sqd_pkg::HANDLER_W-1:0] hid,
      input logic [ARG_W-1:0] arg);
      rsp_word_type r;
      int n;
      int pick;
      r = '0;
      if (func == sqd_pkg::FUNC_SCHEDULE) begin
         n = int'(workers_cfg);
         if (n < 1) n = 1;
         if (n > WORKERS) n = WORKERS;
         pick = 0;
         for (int i = 1; i < n; i++)
            if (fill_count[i] < fill_count[pick]) pick = i;
         r.worker = sqd_pkg::WIDX_W'(pick);
         if (fill_count[pick] >= QUEUE_DEPTH) begin
            r.status = sqd_pkg::STATUS_FULL;
         end else begin
            slot_handler[pick][tail_ptr[pick]] = hid;
            slot_arg[pick][tail_ptr[pick]]     = arg;
            tail_ptr[pick] = (tail_ptr[pick] == QUEUE_DEPTH - 1) ? 0 : tail_ptr[pick] + 1;
            fill_count[pick]++;
            r.status = sqd_pkg::STATUS_DONE;
            r.wake   = (fill_count[pick] == 1);
         end
      end else begin
         r.worker = widx;
         if (fill_count[widx] == 0) begin
            r.status = sqd_pkg::STATUS_EMPTY;
         end else begin
            r.status = sqd_pkg::STATUS_DONE;
            r.hid    = slot_handler[widx][head_ptr[widx]];
            r.arg    = slot_arg[widx][head_ptr[widx]];
            head_ptr[widx] = (head_ptr[widx] == QUEUE_DEPTH - 1) ? 0 : head_ptr[widx] + 1;
            fill_count[widx]--;
         end
      end
      return r;
   endfunction

   // offer one word, wait for acceptance, record its expected response
   task automatic send_word(input logic func, input logic [sqd_pkg::WIDX_W-1:0] widx,
                            input logic [sqd_pkg::HANDLER_W-1:0] hid,
                            input logic [ARG_W-1:0] arg,
                            input logic typed, input rsp_word_type want);
      rsp_word_type predicted;
      push              <= 1'b1;
      req_func          <= func;
      req_worker_index  <= widx;
      req_handler_id    <= hid;
      req_work_argument <= arg;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = predict_dispatch(func, widx, hid, arg);
      expected_words.push_back(typed ? want : predicted);
      words_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // random mix; most takes aim at a loaded queue so pops carry data
   task automatic send_mixed(input int count, input int sched_pct);
      logic                       func;
      logic [sqd_pkg::WIDX_W-1:0] widx;
      int                         start;
      for (int k = 0; k < count; k++) begin
         func = ($urandom_range(0, 99) < sched_pct) ? sqd_pkg::FUNC_SCHEDULE
                                                    : sqd_pkg::FUNC_TAKE;
         widx = sqd_pkg::WIDX_W'($urandom_range(0, WORKERS - 1));
         if (func == sqd_pkg::FUNC_TAKE && $urandom_range(0, 4) != 0) begin
            start = $urandom_range(0, WORKERS - 1);
            for (int j = WORKERS - 1; j >= 0; j--)
               if (fill_count[(start + j) % WORKERS] != 0)
                  widx = sqd_pkg::WIDX_W'((start + j) % WORKERS);
         end
         send_word(func, widx, sqd_pkg::HANDLER_W'($urandom_range(0, 255)), $urandom(),
                   1'b0, '0);
      end
   endtask

   // register write once the block has drained
   task automatic write_workers(input logic [sqd_pkg::CSR_DATA_W-1:0] value);
      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sqd_pkg::REG_WORKERS_IN_USE, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel        <= 1'b0;
      penable     <= 1'b0;
      workers_cfg = value[sqd_pkg::CFG_W-1:0];
   endtask

   // stimulus and end of run
   initial begin
      reset             <= 1'b1;
      push              <= 1'b0;
      req_func          <= sqd_pkg::FUNC_SCHEDULE;
      req_worker_index  <= '0;
      req_handler_id    <= '0;
      req_work_argument <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].func, directed_rows[i].widx, directed_rows[i].hid,
                   directed_rows[i].arg, directed_rows[i].typed, directed_rows[i].want);

      // one worker: fill worker 0 past full, then drain past empty
      write_workers(32'hFFFF_FFF1);
      send_mixed(36, 100);
      repeat (36)
         send_word(sqd_pkg::FUNC_TAKE, '0, sqd_pkg::HANDLER_W'($urandom_range(0, 255)),
                   $urandom(), 1'b0, '0);

      // zero behaves as one, fifteen saturates
      write_workers(32'd0);
      send_mixed(60, 60);
      write_workers(32'd15);
      send_mixed(150, 55);

      // three workers under heavy scheduling to reach full queues
      write_workers(32'd3);
      send_mixed(150, 70);

      repeat (4) begin
         write_workers(($urandom() & 32'hFFFF_FFF0) | $urandom_range(1, WORKERS));
         send_mixed(60, 50);
      end

      calm = 1'b1;
      write_workers(32'd8);
      send_mixed(100, 50);
      push <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, one long hold-off to back the block up
   initial begin
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && words_sent >= 380) begin
            held_off = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && pop && !empty) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: status %0h worker %0d",
                        rsp_status, rsp_chosen_worker);
         end else begin
            want = expected_words.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("chosen_worker", 64'(want.worker), 64'(rsp_chosen_worker));
            check_field("wake_worker", 64'(want.wake), 64'(rsp_wake_worker));
            check_field("taken_handler_id", 64'(want.hid), 64'(rsp_taken_handler_id));
            check_field("taken_argument", 64'(want.arg), 64'(rsp_taken_argument));
         end
      end
   end

endmodule

// ===== sim.f =====
src/sqd_pkg.sv
src/sqd_front.sv
src/sqd_back.sv
src/shortest_queue_dispatcher.sv
verif/shortest_queue_dispatcher_tb.sv
